// ----- rtl/core/skst_pkg.sv -----
// ----------------------------------------------------------------------------
// skst_pkg
// Shared types and constants of the sorted key set table.
// ----------------------------------------------------------------------------
package skst_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_W     = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    status_e                status;
    logic                   found;
    logic [POS_W-1:0]       position;
    logic [CNT_OUT_W-1:0]   entry_count;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/core/skst_if.sv -----
// ----------------------------------------------------------------------------
// skst_if
// Command and response channels of the sorted key set table.
// ----------------------------------------------------------------------------
interface skst_cmd_if;
  logic                               valid;
  logic                               ready;
  skst_pkg::cmd_e                     cmd;
  logic signed [skst_pkg::KEY_W-1:0]  key;

  modport source (output valid, cmd, key, input ready);
  modport sink   (input valid, cmd, key, output ready);
endinterface

interface skst_rsp_if;
  logic                                valid;
  logic                                ready;
  skst_pkg::status_e                   status;
  logic                                found;
  logic [skst_pkg::POS_W-1:0]          position;
  logic [skst_pkg::CNT_OUT_W-1:0]      entry_count;

  modport source (output valid, status, found, position, entry_count, input ready);
  modport sink   (input valid, status, found, position, entry_count, output ready);
endinterface

// ----- rtl/core/skst_mem.sv -----
// ----------------------------------------------------------------------------
// skst_mem
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module skst_mem (
  input  logic                          clk_i,
  input  skst_pkg::mem_req_t            req_i,
  output logic [skst_pkg::KEY_W-1:0]    rdata_o
);

  logic [skst_pkg::KEY_W-1:0] mem_q [skst_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

// ----- rtl/core/skst_ctrl.sv -----
// ----------------------------------------------------------------------------
// skst_ctrl
// Sequencer: linear scan with one shared comparator, then entry shifting.
// ----------------------------------------------------------------------------
module skst_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  skst_pkg::cmd_e                      in_cmd_i,
  input  logic signed [skst_pkg::KEY_W-1:0]   in_key_i,
  output logic                                in_ready_o,
  output logic                                res_valid_o,
  output skst_pkg::res_t                      res_o,
  input  logic                                res_ready_i,
  output skst_pkg::mem_req_t                  mem_o,
  input  logic [skst_pkg::KEY_W-1:0]          mem_rdata_i
);

  localparam int CW = skst_pkg::CNT_W;
  localparam int AW = skst_pkg::ADDR_W;

  skst_pkg::state_e                   state_q, state_d;
  logic [CW-1:0]                      cnt_q, cnt_d;
  skst_pkg::cmd_e                     cmd_q, cmd_d;
  logic signed [skst_pkg::KEY_W-1:0]  key_q, key_d;
  logic [CW-1:0]                      idx_q, idx_d;
  logic [CW-1:0]                      rank_q, rank_d;
  logic                               eq_q, eq_d;
  skst_pkg::res_t                     res_q, res_d;
  logic [CW-1:0]                      idx_m1;
  logic [CW-1:0]                      idx_p1;
  logic                               key_less;

  assign idx_m1   = idx_q - CW'(1);
  assign idx_p1   = idx_q + CW'(1);
  assign key_less = $signed(mem_rdata_i) < key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skst_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    rank_q <= rank_d;
    eq_q   <= eq_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    idx_d       = idx_q;
    rank_d      = rank_q;
    eq_d        = eq_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_o.we    = 1'b0;
    mem_o.waddr = idx_q[AW-1:0];
    mem_o.wdata = mem_rdata_i;
    mem_o.raddr = idx_q[AW-1:0];

    unique case (state_q)
      skst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_cmd_i;
          key_d = in_key_i;
          idx_d = '0;
          res_d.status      = skst_pkg::STAT_OK;
          res_d.found       = 1'b0;
          res_d.position    = '0;
          res_d.entry_count = skst_pkg::CNT_OUT_W'(cnt_q);
          if (in_cmd_i == skst_pkg::CMD_CLEAR) begin
            cnt_d             = '0;
            res_d.entry_count = '0;
            state_d           = skst_pkg::ST_DONE;
          end else if (in_cmd_i == skst_pkg::CMD_INSERT &&
                       cnt_q == CW'(skst_pkg::CAPACITY)) begin
            res_d.status = skst_pkg::STAT_FULL;
            state_d      = skst_pkg::ST_DONE;
          end else begin
            state_d = skst_pkg::ST_SCAN_RD;
          end
        end
      end

      skst_pkg::ST_SCAN_RD: begin
        if (idx_q == cnt_q) begin
          rank_d  = idx_q;
          eq_d    = 1'b0;
          state_d = skst_pkg::ST_DECIDE;
        end else begin
          state_d = skst_pkg::ST_SCAN_CMP;
        end
      end

      skst_pkg::ST_SCAN_CMP: begin
        if (key_less) begin
          idx_d   = idx_p1;
          state_d = skst_pkg::ST_SCAN_RD;
        end else begin
          rank_d  = idx_q;
          eq_d    = (mem_rdata_i == key_q);
          state_d = skst_pkg::ST_DECIDE;
        end
      end

      skst_pkg::ST_DECIDE: begin
        unique case (cmd_q)
          skst_pkg::CMD_INSERT: begin
            idx_d   = cnt_q;
            state_d = skst_pkg::ST_INS_RD;
          end
          skst_pkg::CMD_REMOVE: begin
            if (eq_q) begin
              idx_d   = rank_q;
              state_d = skst_pkg::ST_DEL_RD;
            end else begin
              res_d.status = skst_pkg::STAT_NOT_FOUND;
              state_d      = skst_pkg::ST_DONE;
            end
          end
          skst_pkg::CMD_SEARCH: begin
            if (eq_q) begin
              res_d.found    = 1'b1;
              res_d.position = skst_pkg::POS_W'(rank_q);
            end else begin
              res_d.status = skst_pkg::STAT_NOT_FOUND;
            end
            state_d = skst_pkg::ST_DONE;
          end
          default: begin
            state_d = skst_pkg::ST_DONE;
          end
        endcase
      end

      // Open a hole at the rank by moving entries up, top first.
      skst_pkg::ST_INS_RD: begin
        mem_o.raddr = idx_m1[AW-1:0];
        if (idx_q == rank_q) begin
          mem_o.we          = 1'b1;
          mem_o.waddr       = rank_q[AW-1:0];
          mem_o.wdata       = key_q;
          cnt_d             = cnt_q + CW'(1);
          res_d.position    = skst_pkg::POS_W'(rank_q);
          res_d.entry_count = skst_pkg::CNT_OUT_W'(cnt_q + CW'(1));
          state_d           = skst_pkg::ST_DONE;
        end else begin
          state_d = skst_pkg::ST_INS_WR;
        end
      end

      skst_pkg::ST_INS_WR: begin
        mem_o.we = 1'b1;
        idx_d    = idx_m1;
        state_d  = skst_pkg::ST_INS_RD;
      end

      // Close the gap at the rank by moving entries down.
      skst_pkg::ST_DEL_RD: begin
        mem_o.raddr = idx_p1[AW-1:0];
        if (idx_p1 >= cnt_q) begin
          cnt_d             = cnt_q - CW'(1);
          res_d.found       = 1'b1;
          res_d.position    = skst_pkg::POS_W'(rank_q);
          res_d.entry_count = skst_pkg::CNT_OUT_W'(cnt_q - CW'(1));
          state_d           = skst_pkg::ST_DONE;
        end else begin
          state_d = skst_pkg::ST_DEL_WR;
        end
      end

      skst_pkg::ST_DEL_WR: begin
        mem_o.we = 1'b1;
        idx_d    = idx_p1;
        state_d  = skst_pkg::ST_DEL_RD;
      end

      skst_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = skst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = skst_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/sorted_key_set_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_set_table
// Bounded table of signed keys kept in ascending order.
// ----------------------------------------------------------------------------
// Each command transaction (insert, search, remove, clear) yields exactly one
// response transaction. Keys live in a 64-entry memory with a registered read
// port, and one comparator walks them in rank order; every scan step and every
// entry moved by an insert or remove is a read, then a compare or a write
// back. Clear and a refused insert skip the scan, and any wait for the output
// register to drain lengthens an operation. The command port is ready only
// between operations; a finished response sits in an output register, so the
// next command is taken while the previous response still waits for its sink.
// Insert places a key ahead of any equal keys; remove deletes the first
// occurrence.
// ----------------------------------------------------------------------------
module sorted_key_set_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  skst_cmd_if.sink   cmd_i,
  skst_rsp_if.source rsp_o
);

  skst_pkg::mem_req_t          mem_req;
  logic [skst_pkg::KEY_W-1:0]  mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  skst_pkg::res_t              res;
  logic                        out_valid_q;
  skst_pkg::res_t              out_res_q;

  skst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_cmd_i    (cmd_i.cmd),
    .in_key_i    (cmd_i.key),
    .in_ready_o  (cmd_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  skst_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Load the output register when it is empty or being drained.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_res_q.status;
  assign rsp_o.found       = out_res_q.found;
  assign rsp_o.position    = out_res_q.position;
  assign rsp_o.entry_count = out_res_q.entry_count;

endmodule

// ----- rtl/core/skst_check.sv -----
// ----------------------------------------------------------------------------
// skst_check
// Port-level checks of the sorted key set table, bound to the top level.
// ----------------------------------------------------------------------------
module skst_check (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input skst_pkg::status_e                  status_i,
  input logic                               found_i,
  input logic [skst_pkg::POS_W-1:0]         position_i,
  input logic [skst_pkg::CNT_OUT_W-1:0]     entry_count_i
);

  // A stalled response holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(status_i) && $stable(found_i) && $stable(position_i) &&
      $stable(entry_count_i))
    else $error("stalled response changed");

  // The block works on one command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while busy");

  // A failing status carries no match and no rank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != skst_pkg::STAT_OK |-> !found_i && position_i == '0)
    else $error("failed transaction reports a match");

  // A match is only reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> status_i == skst_pkg::STAT_OK)
    else $error("match with error status");

  // The count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= skst_pkg::CNT_OUT_W'(skst_pkg::CAPACITY))
    else $error("entry count above capacity");

endmodule

bind sorted_key_set_table skst_check u_skst_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .found_i       (rsp_o.found),
  .position_i    (rsp_o.position),
  .entry_count_i (rsp_o.entry_count)
);

// ----- verif/tb_sorted_key_set_table.sv -----
// ----------------------------------------------------------------------------
// tb_sorted_key_set_table
// Self-checking testbench of the sorted key set table.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, sentinel and extreme keys,
// duplicates, misses and clear. Random phases follow that fill, drain or mix
// the table, so it reaches full and refuses inserts. A local copy of the table
// computes each expected response when its command transaction is accepted.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS       = 1550;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;

  localparam logic signed [skst_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [skst_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    skst_pkg::cmd_e                    op;
    logic signed [skst_pkg::KEY_W-1:0] key;
    logic                              typed;
    skst_pkg::res_t                    res;
  } dir_row_t;

  localparam skst_pkg::res_t NO_RES = '0;

  // Typed rows carry the response read straight off the table contents.
  localparam int N_DIR = 22;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{skst_pkg::CMD_SEARCH, 32'sd7,           1'b1,
      '{skst_pkg::STAT_NOT_FOUND, 1'b0, 6'd0, 7'd0}},
    '{skst_pkg::CMD_REMOVE, 32'sd7,           1'b1,
      '{skst_pkg::STAT_NOT_FOUND, 1'b0, 6'd0, 7'd0}},
    '{skst_pkg::CMD_INSERT, KEY_MAX,          1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd0, 7'd1}},
    '{skst_pkg::CMD_INSERT, KEY_MIN,          1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd0, 7'd2}},
    '{skst_pkg::CMD_INSERT, 32'sh8000_0001,   1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd1, 7'd3}},
    '{skst_pkg::CMD_INSERT, 32'sd2147483646,  1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd2, 7'd4}},
    '{skst_pkg::CMD_INSERT, -32'sd2147483646, 1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd2, 7'd5}},
    '{skst_pkg::CMD_INSERT, 32'sd0,           1'b0, NO_RES},
    '{skst_pkg::CMD_INSERT, 32'sd0,           1'b0, NO_RES},
    '{skst_pkg::CMD_SEARCH, 32'sd0,           1'b0, NO_RES},
    '{skst_pkg::CMD_SEARCH, KEY_MIN,          1'b1,
      '{skst_pkg::STAT_OK,        1'b1, 6'd0, 7'd7}},
    '{skst_pkg::CMD_SEARCH, KEY_MAX,          1'b1,
      '{skst_pkg::STAT_OK,        1'b1, 6'd6, 7'd7}},
    '{skst_pkg::CMD_REMOVE, 32'sd0,           1'b0, NO_RES},
    '{skst_pkg::CMD_REMOVE, 32'sd0,           1'b0, NO_RES},
    '{skst_pkg::CMD_REMOVE, 32'sd0,           1'b1,
      '{skst_pkg::STAT_NOT_FOUND, 1'b0, 6'd0, 7'd5}},
    '{skst_pkg::CMD_SEARCH, -32'sd1,          1'b0, NO_RES},
    '{skst_pkg::CMD_REMOVE, KEY_MAX,          1'b0, NO_RES},
    '{skst_pkg::CMD_REMOVE, KEY_MIN,          1'b0, NO_RES},
    '{skst_pkg::CMD_CLEAR,  32'shFFFF_FFFF,   1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd0, 7'd0}},
    '{skst_pkg::CMD_SEARCH, KEY_MIN,          1'b1,
      '{skst_pkg::STAT_NOT_FOUND, 1'b0, 6'd0, 7'd0}},
    '{skst_pkg::CMD_INSERT, -32'sd5,          1'b0, NO_RES},
    '{skst_pkg::CMD_CLEAR,  32'sd0,           1'b1,
      '{skst_pkg::STAT_OK,        1'b0, 6'd0, 7'd0}}
  };

  logic clk;
  logic rst_n;

  skst_cmd_if cmd_if ();
  skst_rsp_if rsp_if ();

  sorted_key_set_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Local copy of the table, updated at each accepted command transaction
  logic signed [skst_pkg::KEY_W-1:0] held_keys [skst_pkg::CAPACITY];
  int unsigned                       held_count;

  skst_pkg::res_t pending_rsp_q [$];
  int unsigned    n_errors;
  int unsigned    n_sent;
  int unsigned    cycle_cnt;
  int unsigned    hold_requests;
  int unsigned    burst_left;

  function automatic skst_pkg::res_t apply_op(skst_pkg::cmd_e op,
                                              logic signed [skst_pkg::KEY_W-1:0] k);
    skst_pkg::res_t r;
    int             rank;
    int             j;
    r    = '0;
    rank = 0;
    if (op != skst_pkg::CMD_CLEAR) begin
      while (rank < held_count && held_keys[rank] < k) rank++;
    end
    case (op)
      skst_pkg::CMD_INSERT: begin
        if (held_count >= skst_pkg::CAPACITY) begin
          r.status = skst_pkg::STAT_FULL;
        end else begin
          for (j = held_count; j > rank; j--) held_keys[j] = held_keys[j-1];
          held_keys[rank] = k;
          held_count++;
          r.position = rank[skst_pkg::POS_W-1:0];
        end
      end
      skst_pkg::CMD_SEARCH, skst_pkg::CMD_REMOVE: begin
        if (rank < held_count && held_keys[rank] == k) begin
          r.found    = 1'b1;
          r.position = rank[skst_pkg::POS_W-1:0];
          if (op == skst_pkg::CMD_REMOVE) begin
            for (j = rank; j + 1 < held_count; j++) held_keys[j] = held_keys[j+1];
            held_count--;
          end
        end else begin
          r.status = skst_pkg::STAT_NOT_FOUND;
        end
      end
      default: held_count = 0;
    endcase
    r.entry_count = held_count[skst_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [skst_pkg::KEY_W-1:0] pick_key(int held_pct);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < held_pct && held_count > 0) return held_keys[$urandom_range(0, held_count - 1)];
    if (sel < held_pct + 25) return $signed($urandom_range(0, 16)) - 8;
    if (sel < held_pct + 35) begin
      case ($urandom_range(0, 6))
        0:       return KEY_MAX;
        1:       return KEY_MIN;
        2:       return KEY_MIN + 1;
        3:       return KEY_MAX - 1;
        4:       return KEY_MIN + 2;
        5:       return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic skst_pkg::cmd_e pick_cmd(phase_e ph);
    int sel;
    sel = $urandom_range(0, 199);
    case (ph)
      PH_FILL: begin
        if (sel < 144) return skst_pkg::CMD_INSERT;
        if (sel < 172) return skst_pkg::CMD_SEARCH;
        if (sel < 199) return skst_pkg::CMD_REMOVE;
      end
      PH_DRAIN: begin
        if (sel < 30)  return skst_pkg::CMD_INSERT;
        if (sel < 70)  return skst_pkg::CMD_SEARCH;
        if (sel < 196) return skst_pkg::CMD_REMOVE;
      end
      default: begin
        if (sel < 70)  return skst_pkg::CMD_INSERT;
        if (sel < 130) return skst_pkg::CMD_SEARCH;
        if (sel < 188) return skst_pkg::CMD_REMOVE;
      end
    endcase
    return skst_pkg::CMD_CLEAR;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(skst_pkg::cmd_e op, logic signed [skst_pkg::KEY_W-1:0] k,
                         logic typed, skst_pkg::res_t typed_res);
    skst_pkg::res_t predicted;
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= op;
    cmd_if.key   <= k;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = apply_op(op, k);
    pending_rsp_q.push_back(typed ? typed_res : predicted);
    n_sent++;
    @(negedge clk);
  endtask

  // Close a burst now and then with a gap of random length.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (pending_rsp_q.size() != 0);
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      n_errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    cycle_cnt = 0;
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Response monitor: compare each response transaction with the oldest one due
  always @(posedge clk) begin
    skst_pkg::res_t due;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected response: status %0d found %0d position %0d count %0d",
                 $time, rsp_if.status, rsp_if.found, rsp_if.position, rsp_if.entry_count);
        n_errors++;
      end else begin
        due = pending_rsp_q.pop_front();
        check_field("status", due.status, rsp_if.status);
        check_field("found", due.found, rsp_if.found);
        check_field("position", due.position, rsp_if.position);
        check_field("entry_count", due.entry_count, rsp_if.entry_count);
      end
    end
  end

  // Receiver: ready pattern changes mode after each run of random length
  initial begin
    rx_mode_e    mode;
    int          left;
    int unsigned hold_served;
    logic        rdy;
    mode            = RX_STREAM;
    left            = 0;
    hold_served     = 0;
    rsp_if.ready    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (left == 0) begin
          case ($urandom_range(0, 2))
            0:       mode = RX_STREAM;
            1:       mode = RX_RANDOM;
            default: mode = RX_SPARSE;
          endcase
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_STREAM: rdy = 1'b1;
          RX_RANDOM: rdy = $urandom_range(0, 1);
          default:   rdy = (left % 3 == 0);
        endcase
        rsp_if.ready <= rdy;
      end
    end
  end

  // Sender: directed table, then random phases
  initial begin
    phase_e ph;
    int     phase_len;
    bit     held_off;
    n_errors      = 0;
    n_sent        = 0;
    held_count    = 0;
    hold_requests = 0;
    burst_left    = 0;
    held_off      = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = skst_pkg::CMD_INSERT;
    cmd_if.key    = '0;
    wait (rst_n === 1'b1);
    repeat (2) @(negedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      send_op(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].res);
      pace_sender();
    end
    // hold off until every response of the directed table is back
    wait_drained();

    ph = PH_FILL;
    while (n_sent < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) wait_drained();
      // stall the response side once while the table is being filled
      if (ph == PH_FILL && !held_off) begin
        held_off = 1'b1;
        hold_requests++;
      end
      phase_len = (ph == PH_FILL) ? $urandom_range(100, 250) : $urandom_range(40, 150);
      for (int n = 0; n < phase_len && n_sent < N_ITEMS; n++) begin
        skst_pkg::cmd_e op;
        op = pick_cmd(ph);
        send_op(op, pick_key(op == skst_pkg::CMD_INSERT ? 15 : 55), 1'b0, NO_RES);
        pace_sender();
      end
      case ($urandom_range(0, 2))
        0:       ph = PH_FILL;
        1:       ph = PH_DRAIN;
        default: ph = PH_MIXED;
      endcase
    end
    cmd_if.valid <= 1'b0;

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
